>>> hw/rtl/rbs_pkg.sv
// Shared constants, types and helpers for the ray versus box slab test.
package rbs_pkg;

	localparam int CW    = 32;          // coordinate width
	localparam int FB    = 16;          // fraction bits
	localparam int QW    = CW + FB;     // quotient bits, one divide stage each
	localparam int DEPTH = QW + 3;      // prep, divide steps, finish, merge
	localparam int IDXW  = 3;           // register index width

	// register indexes
	localparam logic [IDXW-1:0] REG_MIN_X = 3'd0;
	localparam logic [IDXW-1:0] REG_MIN_Y = 3'd1;
	localparam logic [IDXW-1:0] REG_MIN_Z = 3'd2;
	localparam logic [IDXW-1:0] REG_MAX_X = 3'd3;
	localparam logic [IDXW-1:0] REG_MAX_Y = 3'd4;
	localparam logic [IDXW-1:0] REG_MAX_Z = 3'd5;

	localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

	localparam logic [QW-1:0] LIM_POS = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [QW-1:0] LIM_NEG = LIM_POS + QW'(1);

	// what one axis lane finds
	typedef struct packed {
		logic signed [CW-1:0] near_t;
		logic signed [CW-1:0] far_t;
		logic                 miss;
	} lane_t;

	// saturate an unsigned quotient and apply its sign
	function automatic logic signed [CW-1:0] sat_fix(input logic [QW-1:0] q, input logic neg);
		logic [QW-1:0] lim;
		logic [QW-1:0] qq;
		logic [CW:0]   mag;
		logic [CW:0]   res;
		lim = neg ? LIM_NEG : LIM_POS;
		qq  = (q > lim) ? lim : q;
		mag = qq[CW:0];
		res = neg ? (~mag + (CW+1)'(1)) : mag;
		return res[CW-1:0];
	endfunction

endpackage

>>> hw/rtl/rbs_lane.sv
// One axis lane: slab distances through two pipelined restoring dividers.
module rbs_lane (
	input  logic                                 clk,
	input  logic [rbs_pkg::DEPTH-1:0]            en,
	input  logic signed [rbs_pkg::CW-1:0]        origin,
	input  logic signed [rbs_pkg::CW-1:0]        dir,
	input  logic signed [rbs_pkg::CW-1:0]        box_lo,
	input  logic signed [rbs_pkg::CW-1:0]        box_hi,
	output rbs_pkg::lane_t                       res
);

	localparam int CW = rbs_pkg::CW;
	localparam int QW = rbs_pkg::QW;

	// prepare magnitudes and signs
	logic              nneg_lo, nneg_hi, dneg;
	logic [CW:0]       dif_lo, dif_hi;
	logic [CW-1:0]     dabs;

	always_comb begin
		nneg_lo = box_lo < origin;
		nneg_hi = box_hi < origin;
		dneg    = dir[CW-1];
		dif_lo  = nneg_lo ? ({origin[CW-1], origin} - {box_lo[CW-1], box_lo})
		                  : ({box_lo[CW-1], box_lo} - {origin[CW-1], origin});
		dif_hi  = nneg_hi ? ({origin[CW-1], origin} - {box_hi[CW-1], box_hi})
		                  : ({box_hi[CW-1], box_hi} - {origin[CW-1], origin});
		dabs    = dneg ? (~dir + CW'(1)) : dir;
	end

	// per-stage registers, index 0 is the prep stage
	logic [CW-1:0] mag_lo_q [0:QW];
	logic [CW-1:0] mag_hi_q [0:QW];
	logic [CW-1:0] rem_lo_q [0:QW];
	logic [CW-1:0] rem_hi_q [0:QW];
	logic [QW-1:0] quo_lo_q [0:QW];
	logic [QW-1:0] quo_hi_q [0:QW];
	logic [CW-1:0] den_q    [0:QW];
	logic          neg_lo_q [0:QW];
	logic          neg_hi_q [0:QW];
	logic          zero_q   [0:QW];
	logic          inside_q [0:QW];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_lo_q[0] <= dif_lo[CW-1:0];
			mag_hi_q[0] <= dif_hi[CW-1:0];
			rem_lo_q[0] <= '0;
			rem_hi_q[0] <= '0;
			quo_lo_q[0] <= '0;
			quo_hi_q[0] <= '0;
			den_q[0]    <= dabs;
			neg_lo_q[0] <= nneg_lo ^ dneg;
			neg_hi_q[0] <= nneg_hi ^ dneg;
			zero_q[0]   <= (dir == '0);
			inside_q[0] <= (box_lo <= origin) && (origin <= box_hi);
		end
	end

	// one quotient bit per stage for each divider
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [CW:0] part_lo, part_hi, sub_lo, sub_hi;
		logic        ge_lo, ge_hi;

		always_comb begin
			part_lo = {rem_lo_q[k-1], mag_lo_q[k-1][CW-1]};
			part_hi = {rem_hi_q[k-1], mag_hi_q[k-1][CW-1]};
			sub_lo  = part_lo - {1'b0, den_q[k-1]};
			sub_hi  = part_hi - {1'b0, den_q[k-1]};
			ge_lo   = part_lo >= {1'b0, den_q[k-1]};
			ge_hi   = part_hi >= {1'b0, den_q[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				mag_lo_q[k] <= {mag_lo_q[k-1][CW-2:0], 1'b0};
				mag_hi_q[k] <= {mag_hi_q[k-1][CW-2:0], 1'b0};
				rem_lo_q[k] <= ge_lo ? sub_lo[CW-1:0] : part_lo[CW-1:0];
				rem_hi_q[k] <= ge_hi ? sub_hi[CW-1:0] : part_hi[CW-1:0];
				quo_lo_q[k] <= {quo_lo_q[k-1][QW-2:0], ge_lo};
				quo_hi_q[k] <= {quo_hi_q[k-1][QW-2:0], ge_hi};
				den_q[k]    <= den_q[k-1];
				neg_lo_q[k] <= neg_lo_q[k-1];
				neg_hi_q[k] <= neg_hi_q[k-1];
				zero_q[k]   <= zero_q[k-1];
				inside_q[k] <= inside_q[k-1];
			end
		end
	end

	// saturate, order near and far, handle a zero direction
	logic signed [CW-1:0] t_lo, t_hi;
	rbs_pkg::lane_t       fin;

	always_comb begin
		t_lo = rbs_pkg::sat_fix(quo_lo_q[QW], neg_lo_q[QW]);
		t_hi = rbs_pkg::sat_fix(quo_hi_q[QW], neg_hi_q[QW]);
		if (zero_q[QW]) begin
			fin.miss   = !inside_q[QW];
			fin.near_t = inside_q[QW] ? rbs_pkg::SMIN : rbs_pkg::SMAX;
			fin.far_t  = inside_q[QW] ? rbs_pkg::SMAX : rbs_pkg::SMIN;
		end else begin
			fin.miss   = 1'b0;
			fin.near_t = (t_lo < t_hi) ? t_lo : t_hi;
			fin.far_t  = (t_lo < t_hi) ? t_hi : t_lo;
		end
	end

	rbs_pkg::lane_t res_s1;

	always_ff @(posedge clk) begin
		if (en[QW+1]) begin
			res_s1 <= fin;
		end
	end

	assign res = res_s1;

endmodule

>>> hw/rtl/rbs_merge.sv
// Merge stage: combine the three axis lanes into tmin, tmax and the hit flag.
module rbs_merge (
	input  logic                          clk,
	input  logic                          en,
	input  rbs_pkg::lane_t                lane_x,
	input  rbs_pkg::lane_t                lane_y,
	input  rbs_pkg::lane_t                lane_z,
	output logic                          hit,
	output logic signed [rbs_pkg::CW-1:0] entry_dist,
	output logic signed [rbs_pkg::CW-1:0] exit_dist
);

	logic signed [rbs_pkg::CW-1:0] nxy, fxy, tmin, tmax;
	logic                          miss;

	// largest near, smallest far
	always_comb begin
		nxy  = (lane_x.near_t > lane_y.near_t) ? lane_x.near_t : lane_y.near_t;
		tmin = (lane_z.near_t > nxy) ? lane_z.near_t : nxy;
		fxy  = (lane_x.far_t < lane_y.far_t) ? lane_x.far_t : lane_y.far_t;
		tmax = (lane_z.far_t < fxy) ? lane_z.far_t : fxy;
		miss = lane_x.miss || lane_y.miss || lane_z.miss;
	end

	logic                          hit_s1;
	logic signed [rbs_pkg::CW-1:0] tmin_s1, tmax_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1  <= !(miss || tmax[rbs_pkg::CW-1] || (tmin > tmax));
			tmin_s1 <= tmin;
			tmax_s1 <= tmax;
		end
	end

	assign hit        = hit_s1;
	assign entry_dist = tmin_s1;
	assign exit_dist  = tmax_s1;

endmodule

>>> hw/rtl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
//
// Usage:
//   Write the box corners over the cfg port (cfg_we, cfg_index, cfg_data)
//   while no ray is in flight: index 0..2 minimum x/y/z, 3..5 maximum x/y/z.
//   Rays enter on the in_valid/in_ready channel, one origin and direction
//   per request; results leave on out_valid/out_ready with hit, entry_dist
//   (tmin) and exit_dist (tmax), all signed Q16.16.
//   Three axis lanes run side by side, each with two 48-stage restoring
//   dividers producing one quotient bit per stage; a merge stage combines
//   them. Throughput is one ray per cycle while out_ready stays high, as
//   the divide stages are fully pipelined.
//   Each stage holds its request while the one after it is full and
//   stalled, so empty slots close up and input keeps being taken while a
//   result waits; in_ready drops only once every stage is full.
//   Reset clears all stage valid flags and the box registers to zero.
module ray_box_slab_test (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rbs_pkg::IDXW-1:0]          cfg_index,
	input  logic [rbs_pkg::CW-1:0]            cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [rbs_pkg::CW-1:0]     origin_x,
	input  logic signed [rbs_pkg::CW-1:0]     origin_y,
	input  logic signed [rbs_pkg::CW-1:0]     origin_z,
	input  logic signed [rbs_pkg::CW-1:0]     dir_x,
	input  logic signed [rbs_pkg::CW-1:0]     dir_y,
	input  logic signed [rbs_pkg::CW-1:0]     dir_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [rbs_pkg::CW-1:0]     entry_dist,
	output logic signed [rbs_pkg::CW-1:0]     exit_dist
);

	localparam int DEPTH = rbs_pkg::DEPTH;

	// box registers
	logic signed [rbs_pkg::CW-1:0] min_x_q, min_y_q, min_z_q;
	logic signed [rbs_pkg::CW-1:0] max_x_q, max_y_q, max_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			min_z_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rbs_pkg::REG_MIN_X: min_x_q <= cfg_data;
				rbs_pkg::REG_MIN_Y: min_y_q <= cfg_data;
				rbs_pkg::REG_MIN_Z: min_z_q <= cfg_data;
				rbs_pkg::REG_MAX_X: max_x_q <= cfg_data;
				rbs_pkg::REG_MAX_Y: max_y_q <= cfg_data;
				rbs_pkg::REG_MAX_Z: max_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its successor moves
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] en;

	always_comb begin
		en[DEPTH-1] = !vld_q[DEPTH-1] || out_ready;
		for (int k = DEPTH - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < DEPTH; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[DEPTH-1];

	rbs_pkg::lane_t res_x, res_y, res_z;

	rbs_lane u_lane_x (
		.clk    (clk),
		.en     (en),
		.origin (origin_x),
		.dir    (dir_x),
		.box_lo (min_x_q),
		.box_hi (max_x_q),
		.res    (res_x)
	);

	rbs_lane u_lane_y (
		.clk    (clk),
		.en     (en),
		.origin (origin_y),
		.dir    (dir_y),
		.box_lo (min_y_q),
		.box_hi (max_y_q),
		.res    (res_y)
	);

	rbs_lane u_lane_z (
		.clk    (clk),
		.en     (en),
		.origin (origin_z),
		.dir    (dir_z),
		.box_lo (min_z_q),
		.box_hi (max_z_q),
		.res    (res_z)
	);

	rbs_merge u_merge (
		.clk        (clk),
		.en         (en[DEPTH-1]),
		.lane_x     (res_x),
		.lane_y     (res_y),
		.lane_z     (res_z),
		.hit        (hit),
		.entry_dist (entry_dist),
		.exit_dist  (exit_dist)
	);

endmodule
